/* hdl/shws_pkg.sv */
// Shared types and constants for the path hash worker selector.
package shws_pkg;

  localparam int HASH_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int STEP_W  = $clog2(HASH_W);
  localparam int LIMIT_W = 16;

  localparam logic [HASH_W-1:0] HASH_SEED  = 64'd5381;
  localparam int                HASH_SHIFT = 5;

  // controller -> datapath
  typedef struct packed {
    logic hash_upd;   // fold accepted byte into running hash
    logic div_load;   // last byte: latch hash as dividend, reseed hash
    logic div_step;   // one remainder bit
    logic out_load;   // move remainder into output register
  } shws_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;   // current step is the final one
  } shws_stat_t;

endpackage

/* hdl/shws_if.sv */
// Channel interfaces: path byte input, worker index output, count write.
interface shws_in_if;
  import shws_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] path_byte;
  logic              is_last;
  modport source (output valid, output path_byte, output is_last, input ready);
  modport sink   (input valid, input path_byte, input is_last, output ready);
endinterface

interface shws_out_if;
  import shws_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] worker_index;
  modport source (output valid, output worker_index, input ready);
  modport sink   (input valid, input worker_index, output ready);
endinterface

interface shws_cfg_if;
  import shws_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] worker_count;
  modport source (output valid, output worker_count, input ready);
  modport sink   (input valid, input worker_count, output ready);
endinterface

/* hdl/shws_dp.sv */
// Datapath: running hash, count register, bit-serial remainder, output register.
module shws_dp import shws_pkg::*; #(
  parameter int MAX_WORKERS = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  shws_cmd_t         cmd,
  output shws_stat_t        stat,
  input  logic [BYTE_W-1:0] path_byte,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_count,
  output logic [CNT_W-1:0]  worker_index
);

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] byte_sext;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_sat;
  logic [HASH_W-1:0] dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [CNT_W:0]    rem_ext;
  logic [CNT_W:0]    rem_sub;
  logic [CNT_W-1:0]  div_n_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  idx_r;

  assign byte_sext = {{(HASH_W-BYTE_W){path_byte[BYTE_W-1]}}, path_byte};
  assign hash_nxt  = (hash_r << HASH_SHIFT) + hash_r + byte_sext;

  assign count_sat = ({{(LIMIT_W-CNT_W){1'b0}}, count_r} > LIMIT_W'(MAX_WORKERS)) ?
                     CNT_W'(MAX_WORKERS) : count_r;

  // restoring remainder, one dividend bit per step
  assign rem_ext = {rem_r, dvd_r[HASH_W-1]};
  assign rem_sub = rem_ext - {1'b0, div_n_r};
  assign rem_nxt = (rem_ext >= {1'b0, div_n_r}) ? rem_sub[CNT_W-1:0] : rem_ext[CNT_W-1:0];

  assign stat.div_done = (step_r == STEP_W'(HASH_W-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= HASH_SEED;
      count_r <= CNT_W'(1);
      step_r  <= '0;
    end else begin
      if (cmd.div_load) begin
        hash_r <= HASH_SEED;
      end else if (cmd.hash_upd) begin
        hash_r <= hash_nxt;
      end
      if (cfg_we) begin
        count_r <= cfg_count;
      end
      if (cmd.div_load) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r   <= hash_nxt;
      rem_r   <= '0;
      div_n_r <= count_sat;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      idx_r <= (div_n_r == '0) ? '0 : rem_r;
    end
  end

  assign worker_index = idx_r;

endmodule

/* hdl/shws_ctrl.sv */
// Controller: accept / divide / hand-off sequencing and output valid.
module shws_ctrl import shws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_is_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output shws_cmd_t  cmd,
  input  shws_stat_t stat
);

  typedef enum logic [1:0] {S_ACCEPT, S_DIV, S_HOLD} state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_vld_r;
  logic   out_vld_nxt;
  logic   in_acc;

  assign in_ready  = (state_r == S_ACCEPT);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_vld_r;

  always_comb begin
    cmd.hash_upd = in_acc;
    cmd.div_load = in_acc && in_is_last;
    cmd.div_step = (state_r == S_DIV);
    cmd.out_load = (state_r == S_HOLD) && (!out_vld_r || out_ready);

    state_nxt = state_r;
    case (state_r)
      S_ACCEPT: if (cmd.div_load) state_nxt = S_DIV;
      S_DIV:    if (stat.div_done) state_nxt = S_HOLD;
      S_HOLD:   if (cmd.out_load) state_nxt = S_ACCEPT;
      default:  state_nxt = S_ACCEPT;
    endcase

    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_ACCEPT;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

/* hdl/string_hash_worker_select.sv */
// Top level: djb2 path hash reduced to a worker index.
//
// Path bytes arrive one per beat on in_bus and are folded into a 64-bit
// djb2 hash (seed 5381, hash*33 + byte, the byte taken as signed 8-bit and
// sign extended, wrapping mod 2^64). A byte without is_last yields nothing
// and is taken at once, so such bytes stream at one per cycle. The byte marked
// is_last is folded in and then the hash is reduced modulo the configured
// worker count by a bit-serial restoring remainder unit, one hash bit per
// step; the remainder is then moved into the output register. No path byte
// is taken until that move, which waits while an earlier index is stalled
// on out_bus. The running hash is reseeded as soon as the last
// byte is taken. worker_index is the remainder, or 0 when the count is 0;
// a count above MAX_WORKERS is clamped to MAX_WORKERS. The count is written
// through cfg_bus (always ready, reset value 1) and must only change while
// no path is in flight. A finished index waits in the output register and
// does not block the next path's bytes; only a second finished index waits
// for it to drain.
module string_hash_worker_select import shws_pkg::*; #(
  parameter int MAX_WORKERS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  shws_in_if.sink    in_bus,
  shws_out_if.source out_bus,
  shws_cfg_if.sink   cfg_bus
);

  shws_cmd_t  cmd;
  shws_stat_t stat;

  // count register takes a write every cycle it is offered
  assign cfg_bus.ready = 1'b1;

  shws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_is_last (in_bus.is_last),
    .in_ready   (in_bus.ready),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  shws_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .path_byte    (in_bus.path_byte),
    .cfg_we       (cfg_bus.valid),
    .cfg_count    (cfg_bus.worker_count),
    .worker_index (out_bus.worker_index)
  );

endmodule

/* hdl/shws_chk.sv */
// Port-level checker for the worker selector, bound to the top level.
module shws_chk import shws_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_is_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_index
);

  // a finished beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("output beat dropped or changed while stalled");

  // a byte that is not last never produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_last && !out_valid |=> !out_valid)
    else $error("result appeared after a non-last byte");

  // the remainder unit is busy after a last byte; an earlier index may still wait
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready ##1 !in_ready)
    else $error("input taken while reducing the hash");

  // input stays open through a run of non-last bytes
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_last |=> in_ready)
    else $error("input stalled within a path");

endmodule

bind string_hash_worker_select shws_chk u_shws_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_is_last (in_bus.is_last),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_index  (out_bus.worker_index)
);

/* tb/tb_string_hash_worker_select.sv */
// Testbench for the djb2 path hash worker selector: random paths, counts and stalls.
`timescale 1ns / 100ps

module tb_string_hash_worker_select;
  import shws_pkg::*;

  // Depth-wise limits and timing
  localparam int          MAX_WORKERS_TB = 255;
  localparam logic [63:0] DJB2_SEED      = 64'd5381;
  localparam int          TARGET_BEATS   = 1700;
  // A last byte costs 64 remainder steps plus the output load; wait a bit longer.
  localparam int          SETTLE_CYCLES  = 80;
  localparam int          END_CYCLES     = 100;
  localparam longint      CYCLE_LIMIT    = 3_000_000;

  // What the driver does with one queue entry
  typedef enum logic [1:0] {
    OP_BEAT,   // present one path byte on the input channel
    OP_CFG,    // write worker_count
    OP_DRAIN   // hold off until every index has come back, then settle
  } path_op_kind_t;

  typedef struct {
    path_op_kind_t kind;
    logic [7:0]    data;   // path byte, or count for OP_CFG
    logic          last;
    int unsigned   gap;    // idle cycles after this beat is taken
  } path_op_t;

  logic clk;
  logic rst_n;

  shws_in_if  in_bus ();
  shws_out_if out_bus ();
  shws_cfg_if cfg_bus ();

  string_hash_worker_select #(
    .MAX_WORKERS (MAX_WORKERS_TB)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Stimulus queue, filled up front and drained by the driver
  path_op_t    path_ops[$];
  path_op_t    cur_op;
  int unsigned gap_left;
  int unsigned settle_left;
  logic        drv_in_valid;
  logic        drv_cfg_valid;

  // Predictor state and indexes still owed by the block
  logic [63:0] hash_acc;
  logic [7:0]  count_model;
  logic [7:0]  index_due_q[$];
  logic [7:0]  index_due;
  int          results_owed;   // updated with NBA so the driver sees a stable value
  int          err_cnt;

  // Result-side back-pressure
  int unsigned stall_left;
  int unsigned calm_left;
  logic        calm_mode;
  longint      cycle_cnt;

  // Idle length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // Gap after an input beat; zero in calm stretches and about half the time otherwise.
  function automatic int unsigned beat_gap(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  task automatic add_beat(logic [7:0] b, logic last, int unsigned gap);
    path_op_t op;
    op.kind = OP_BEAT;
    op.data = b;
    op.last = last;
    op.gap  = gap;
    path_ops.push_back(op);
  endtask

  task automatic add_cfg(logic [7:0] cnt);
    path_op_t op;
    op.kind = OP_CFG;
    op.data = cnt;
    op.last = 1'b0;
    op.gap  = 0;
    path_ops.push_back(op);
  endtask

  task automatic add_drain();
    path_op_t op;
    op.kind = OP_DRAIN;
    op.data = '0;
    op.last = 1'b0;
    op.gap  = 0;
    path_ops.push_back(op);
  endtask

  // Random path: mostly path-like characters, the rest any byte value.
  task automatic add_path(bit calm, output int unsigned n_beats);
    int unsigned len;
    logic [7:0]  b;
    int unsigned r;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15)      b = 8'h2F;                              // '/'
      else if (r < 60) b = 8'h61 + 8'($urandom_range(0, 25));  // a..z
      else if (r < 70) b = 8'h2E;                              // '.'
      else             b = 8'($urandom_range(0, 255));
      add_beat(b, (i == len - 1), beat_gap(calm));
    end
    n_beats = len;
  endtask

  // Fold one accepted byte into the djb2 hash; a last byte yields one index.
  task automatic hash_path_byte(logic [7:0] b, logic last);
    logic [63:0] n;
    hash_acc = (hash_acc << 5) + hash_acc + {{56{b[7]}}, b};
    if (last) begin
      n = (count_model > MAX_WORKERS_TB) ? 64'(MAX_WORKERS_TB) : 64'(count_model);
      index_due_q.push_back((n == 0) ? 8'd0 : 8'(hash_acc % n));
      hash_acc = DJB2_SEED;
    end
  endtask

  // Clock and known input levels from time zero
  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.path_byte     = '0;
    in_bus.is_last       = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.worker_count = '0;
    out_bus.ready        = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Driver: one queue entry at a time, all inputs updated once per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      cfg_bus.valid <= 1'b0;
      gap_left      = 0;
      settle_left   = 0;
    end else begin
      drv_in_valid  = in_bus.valid && !in_bus.ready;
      drv_cfg_valid = cfg_bus.valid && !cfg_bus.ready;
      if (!drv_in_valid && !drv_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (path_ops.size() > 0) begin
          cur_op = path_ops[0];
          case (cur_op.kind)
            OP_BEAT: begin
              drv_in_valid = 1'b1;
              in_bus.path_byte <= cur_op.data;
              in_bus.is_last   <= cur_op.last;
              gap_left = cur_op.gap;
              void'(path_ops.pop_front());
            end
            OP_CFG: begin
              drv_cfg_valid = 1'b1;
              cfg_bus.worker_count <= cur_op.data;
              void'(path_ops.pop_front());
            end
            OP_DRAIN: begin
              // Restart the settle count while anything is still moving.
              if (in_bus.valid || cfg_bus.valid || results_owed != 0) begin
                settle_left = 0;
              end else if (settle_left < SETTLE_CYCLES) begin
                settle_left++;
              end else begin
                settle_left = 0;
                void'(path_ops.pop_front());
              end
            end
            default: ;
          endcase
        end
      end
      in_bus.valid  <= drv_in_valid;
      cfg_bus.valid <= drv_cfg_valid;
    end
  end

  // Monitor: tracks count writes and input beats, checks each output beat,
  // and drives out_bus.ready with calm and stalling stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hash_acc     = DJB2_SEED;
      count_model  = 8'd1;
      index_due_q.delete();
      results_owed <= 0;
      stall_left   = 0;
      calm_left    = 0;
      calm_mode    = 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready)
        count_model = cfg_bus.worker_count;
      if (in_bus.valid && in_bus.ready)
        hash_path_byte(in_bus.path_byte, in_bus.is_last);
      if (out_bus.valid && out_bus.ready) begin
        if (index_due_q.size() == 0) begin
          $error("worker_index: expected none, actual %0d", out_bus.worker_index);
          err_cnt++;
        end else begin
          index_due = index_due_q.pop_front();
          if (out_bus.worker_index !== index_due) begin
            $error("worker_index: expected %0d, actual %0d", index_due, out_bus.worker_index);
            err_cnt++;
          end
        end
      end
      results_owed <= index_due_q.size();

      if (calm_left > 0) begin
        calm_left--;
      end else begin
        calm_mode = 1'($urandom_range(0, 1));
        calm_left = $urandom_range(100, 400);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm_mode && $urandom_range(0, 4) == 0) begin
        stall_left = idle_len() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus plan and end of run
  initial begin
    int unsigned beats;
    int unsigned n;
    int unsigned phase;
    int unsigned n_paths;
    bit          calm;
    logic [7:0]  cnt;
    logic [7:0]  sweep[] = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd16,
                             8'd33, 8'd100, 8'd128, 8'd200, 8'd254};

    err_cnt   = 0;
    cycle_cnt = 0;

    // Directed: count still at its reset value of 1, so the index is 0
    add_beat(8'h61, 1'b1, 0);
    // Zero count selects worker 0
    add_drain();
    add_cfg(8'd0);
    add_beat(8'hFF, 1'b0, 0);
    add_beat(8'h80, 1'b1, 0);
    // Largest count; single-byte paths at the byte extremes and the sign boundary,
    // back to back so the second index waits behind the first
    add_drain();
    add_cfg(8'd255);
    add_beat(8'h00, 1'b1, 0);
    add_beat(8'hFF, 1'b1, 0);
    add_beat(8'h80, 1'b1, 0);
    add_beat(8'h7F, 1'b1, 0);
    add_beat(8'h01, 1'b1, 0);
    // A zero byte that ends a path is hashed like any other
    add_beat(8'h2F, 1'b0, 0);
    add_beat(8'h61, 1'b0, 0);
    add_beat(8'h00, 1'b1, 0);
    add_beat(8'h62, 1'b1, 0);
    add_drain();
    add_cfg(8'd2);
    add_beat(8'hFE, 1'b0, 0);
    add_beat(8'h55, 1'b1, 0);
    // Long run of 0xFF: each byte is sign extended to -1
    add_drain();
    add_cfg(8'd254);
    for (int i = 0; i < 10; i++)
      add_beat(8'hFF, (i == 9), 0);

    // Random phases, each under its own count
    beats = 0;
    phase = 0;
    while (beats < TARGET_BEATS) begin
      if (phase < sweep.size())
        cnt = sweep[phase];
      else if ($urandom_range(0, 4) == 0)
        cnt = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      else
        cnt = 8'($urandom_range(0, 255));
      add_drain();
      add_cfg(cnt);
      calm    = ($urandom_range(0, 9) < 3);
      n_paths = $urandom_range(8, 25);
      for (int unsigned p = 0; p < n_paths; p++) begin
        add_path(calm, n);
        beats += n;
        // Occasionally stop sending until all indexes are back
        if ($urandom_range(0, 19) == 0)
          add_drain();
      end
      phase++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (path_ops.size() != 0 || in_bus.valid || cfg_bus.valid || results_owed != 0);
    repeat (END_CYCLES) @(negedge clk);

    if (index_due_q.size() != 0) begin
      $error("worker_index: %0d expected results never arrived", index_due_q.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
